// ===== sv/q248alu_pkg.sv =====
// ============================================================================
// q248alu_pkg - shared types and constants for the Q24.8 fixed-point ALU
// Word and fraction sizes, operation and status codes, saturation helper.
// ============================================================================
package q248alu_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned OpBits    = 4;
  localparam int unsigned StBits    = 2;

  // quotient of (|a| << FracBits) / |b| needs WordBits + FracBits bits
  localparam int unsigned QuotBits  = WordBits + FracBits;
  localparam int unsigned ProdBits  = 2 * WordBits;
  localparam int unsigned MagBits   = (ProdBits > QuotBits + 1) ? ProdBits : QuotBits + 1;

  // stream payload widths, rounded up to whole bytes
  localparam int unsigned InDataBits  = ((OpBits + 2 * WordBits + 7) / 8) * 8;
  localparam int unsigned OutDataBits = ((WordBits + 1 + StBits + 7) / 8) * 8;

  // stage 0 input register, stage 1 decode, one divide step per stage,
  // one rounding stage; the output register follows the last stage
  localparam int unsigned PipeLast  = QuotBits + 2;

  typedef logic [WordBits-1:0] word_t;

  localparam word_t MaxWord = {1'b0, {(WordBits - 1){1'b1}}};
  localparam word_t MinWord = {1'b1, {(WordBits - 1){1'b0}}};

  typedef enum logic [OpBits-1:0] {
    OP_ADD      = OpBits'(0),
    OP_SUB      = OpBits'(1),
    OP_MUL      = OpBits'(2),
    OP_DIV      = OpBits'(3),
    OP_INC      = OpBits'(4),
    OP_DEC      = OpBits'(5),
    OP_MIN      = OpBits'(6),
    OP_MAX      = OpBits'(7),
    OP_GT       = OpBits'(8),
    OP_LT       = OpBits'(9),
    OP_GE       = OpBits'(10),
    OP_LE       = OpBits'(11),
    OP_EQ       = OpBits'(12),
    OP_NE       = OpBits'(13),
    OP_FROM_INT = OpBits'(14),
    OP_TO_INT   = OpBits'(15)
  } alu_op_e;

  typedef enum logic [StBits-1:0] {
    ST_OK   = StBits'(0),
    ST_OVF  = StBits'(1),
    ST_DIV0 = StBits'(2)
  } status_e;

  typedef struct packed {
    word_t   res;
    logic    cmp;
    status_e st;
  } result_t;

  // sign plus magnitude into the word, saturating
  function automatic result_t sat_pack(logic neg, logic [MagBits-1:0] mag);
    result_t r;
    r.res = '0;
    r.cmp = 1'b0;
    r.st  = ST_OK;
    if (neg) begin
      if (mag > MagBits'(MinWord)) begin
        r.res = MinWord;
        r.st  = ST_OVF;
      end else begin
        r.res = word_t'(MagBits'(0) - mag);
      end
    end else begin
      if (mag > MagBits'(MaxWord)) begin
        r.res = MaxWord;
        r.st  = ST_OVF;
      end else begin
        r.res = mag[WordBits-1:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/q248alu_div_step.sv =====
// ============================================================================
// q248alu_div_step - one restoring division step
// Shifts the next dividend bit into the remainder, trial-subtracts the
// divisor and shifts the quotient bit in at the bottom.
// ============================================================================
module q248alu_div_step (
  input  q248alu_pkg::word_t                    rem_i,
  input  logic [q248alu_pkg::QuotBits-1:0]      nq_i,   // dividend bits above, quotient below
  input  q248alu_pkg::word_t                    dvs_i,
  output q248alu_pkg::word_t                    rem_o,
  output logic [q248alu_pkg::QuotBits-1:0]      nq_o
);

  logic [q248alu_pkg::WordBits:0] trial;
  logic [q248alu_pkg::WordBits:0] diff;
  logic                           ge;

  // remainder stays below the divisor, so the new remainder never needs the top bit of trial kept
  assign trial = {rem_i, nq_i[q248alu_pkg::QuotBits-1]};
  assign diff  = trial - {1'b0, dvs_i};
  assign ge    = (trial >= {1'b0, dvs_i});
  assign rem_o = ge ? diff[q248alu_pkg::WordBits-1:0] : trial[q248alu_pkg::WordBits-1:0];
  assign nq_o  = {nq_i[q248alu_pkg::QuotBits-2:0], ge};

endmodule

// ===== sv/q24_8_fixed_point_alu_top.sv =====
// ============================================================================
// q24_8_fixed_point_alu_top - pipelined signed Q24.8 fixed-point ALU
// Add/sub/inc/dec/min/max/compare/convert plus full-width multiply and divide,
// both rounding half away from zero; saturating on overflow and divide by zero.
// ============================================================================
// Stages: input register, stage 1, divide stages, rounding, output register.
// Throughput: one transaction per cycle, every operation, while skid is empty.
// The depth is set by the divider: one quotient bit per stage, 40 stages.
// Reset (rst_ni low, async) empties the pipeline, the output register and
// the skid register; no transaction is in flight after reset.
// ============================================================================
module q24_8_fixed_point_alu_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [3:0] action, [35:4] a_raw, [67:36] b_raw, rest zero
  input  logic [q248alu_pkg::InDataBits-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [31:0] result_raw, [32] compare_true, [34:33] status, rest zero
  output logic [q248alu_pkg::OutDataBits-1:0]  m_axis_tdata
);

  localparam int unsigned W  = q248alu_pkg::WordBits;
  localparam int unsigned F  = q248alu_pkg::FracBits;
  localparam int unsigned QW = q248alu_pkg::QuotBits;
  localparam int unsigned PL = q248alu_pkg::PipeLast;

  // half an LSB of the product, zero when there are no fraction bits
  localparam logic [q248alu_pkg::ProdBits-1:0] MulRnd =
    (q248alu_pkg::ProdBits'(1) << F) >> 1;

  // Per-stage payload. Simple operations are finished in stage 1 and just
  // ride along in fix; multiply and divide finish in the last two stages.
  typedef struct packed {
    q248alu_pkg::alu_op_e              op;
    logic                              neg;    // result sign for mul/div
    logic                              dz;     // divisor is zero
    q248alu_pkg::result_t              fix;    // result of the simple ops
    q248alu_pkg::word_t                amag;   // |a|
    q248alu_pkg::word_t                dmag;   // |b|, also the divisor
    q248alu_pkg::word_t                rem;    // partial remainder
    logic [QW-1:0]                     nq;     // dividend shifting out, quotient in
    logic [q248alu_pkg::ProdBits-1:0]  acc;    // product, later rounded product
    logic [QW:0]                       qr;     // rounded quotient
  } stage_t;

  // --------------------------------------------------------------------------
  // Flow control. The whole pipe moves together while the skid register is
  // empty; the output register plus skid register let the pipe keep taking
  // transactions while a result waits on m_axis_tready, until the skid register fills.
  // --------------------------------------------------------------------------
  logic                   adv;
  logic                   arrive;
  logic                   in_vld_q;
  logic [PL:1]            vld_q;
  logic                   out_vld_q;
  logic                   skid_vld_q;

  q248alu_pkg::alu_op_e   in_op_q;
  q248alu_pkg::word_t     in_a_q;
  q248alu_pkg::word_t     in_b_q;

  stage_t                 pipe_q [1:PL];
  stage_t                 pipe_d [1:PL];

  q248alu_pkg::result_t   out_d;
  q248alu_pkg::result_t   out_q;
  q248alu_pkg::result_t   skid_q;

  assign adv           = !skid_vld_q;
  assign arrive        = adv && vld_q[PL];
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = q248alu_pkg::OutDataBits'({out_q.st, out_q.cmp, out_q.res});

  // --------------------------------------------------------------------------
  // Stage 1: decode, magnitudes, and all the simple operations
  // --------------------------------------------------------------------------
  logic signed [W-1:0]  a_s;
  logic signed [W-1:0]  b_s;
  logic                 sub_sel;
  q248alu_pkg::word_t   addend;
  logic [W:0]           sum;
  logic                 sum_ovf;
  q248alu_pkg::word_t   sum_sat;
  logic signed [QW-1:0] fx;
  logic                 fx_ovf;
  logic                 lt_s;
  logic                 gt_s;
  logic                 eq_s;
  q248alu_pkg::word_t   amag;
  q248alu_pkg::word_t   bmag;

  assign a_s  = $signed(in_a_q);
  assign b_s  = $signed(in_b_q);
  assign lt_s = (a_s < b_s);
  assign gt_s = (a_s > b_s);
  assign eq_s = (in_a_q == in_b_q);
  assign amag = in_a_q[W-1] ? (W'(0) - in_a_q) : in_a_q;
  assign bmag = in_b_q[W-1] ? (W'(0) - in_b_q) : in_b_q;

  // one adder serves add, sub, inc and dec
  assign sub_sel = (in_op_q == q248alu_pkg::OP_SUB) || (in_op_q == q248alu_pkg::OP_DEC);
  assign addend  = ((in_op_q == q248alu_pkg::OP_INC) || (in_op_q == q248alu_pkg::OP_DEC))
                   ? W'(1) : in_b_q;
  assign sum     = {in_a_q[W-1], in_a_q} + ({addend[W-1], addend} ^ {(W + 1){sub_sel}})
                   + (W + 1)'(sub_sel);
  assign sum_ovf = (sum[W] != sum[W-1]);
  assign sum_sat = sum[W] ? q248alu_pkg::MinWord : q248alu_pkg::MaxWord;

  // from_int: fits unless the bits above the word disagree with the sign
  assign fx     = QW'(a_s) <<< F;
  assign fx_ovf = !((&fx[QW-1:W-1]) || !(|fx[QW-1:W-1]));

  always_comb begin
    q248alu_pkg::result_t fix;
    fix     = '0;
    fix.st  = q248alu_pkg::ST_OK;
    unique case (in_op_q) inside
      q248alu_pkg::OP_ADD, q248alu_pkg::OP_SUB,
      q248alu_pkg::OP_INC, q248alu_pkg::OP_DEC: begin
        fix.res = sum_ovf ? sum_sat : sum[W-1:0];
        fix.st  = sum_ovf ? q248alu_pkg::ST_OVF : q248alu_pkg::ST_OK;
      end
      q248alu_pkg::OP_MIN: fix.res = lt_s ? in_a_q : in_b_q;
      q248alu_pkg::OP_MAX: fix.res = gt_s ? in_a_q : in_b_q;
      q248alu_pkg::OP_GT:  fix.cmp = gt_s;
      q248alu_pkg::OP_LT:  fix.cmp = lt_s;
      q248alu_pkg::OP_GE:  fix.cmp = !lt_s;
      q248alu_pkg::OP_LE:  fix.cmp = !gt_s;
      q248alu_pkg::OP_EQ:  fix.cmp = eq_s;
      q248alu_pkg::OP_NE:  fix.cmp = !eq_s;
      q248alu_pkg::OP_FROM_INT: begin
        if (fx_ovf) begin
          fix.res = in_a_q[W-1] ? q248alu_pkg::MinWord : q248alu_pkg::MaxWord;
          fix.st  = q248alu_pkg::ST_OVF;
        end else begin
          fix.res = fx[W-1:0];
        end
      end
      q248alu_pkg::OP_TO_INT: fix.res = W'(a_s >>> F);
      q248alu_pkg::OP_DIV: begin
        // divide by zero: sign of the dividend picks the rail, zero stays zero
        if (in_b_q == '0) begin
          fix.st = q248alu_pkg::ST_DIV0;
          if (in_a_q == '0) begin
            fix.res = '0;
          end else begin
            fix.res = in_a_q[W-1] ? q248alu_pkg::MinWord : q248alu_pkg::MaxWord;
          end
        end
      end
      default: fix = '0;  // multiply finishes at the end of the pipe
    endcase

    pipe_d[1].op   = in_op_q;
    pipe_d[1].neg  = in_a_q[W-1] ^ in_b_q[W-1];
    pipe_d[1].dz   = (in_b_q == '0);
    pipe_d[1].fix  = fix;
    pipe_d[1].amag = amag;
    pipe_d[1].dmag = bmag;
    pipe_d[1].rem  = '0;
    pipe_d[1].nq   = QW'(amag) << F;
    pipe_d[1].acc  = '0;
    pipe_d[1].qr   = '0;
  end

  // --------------------------------------------------------------------------
  // Stages 2..QW+1: one quotient bit per stage; the product is formed on
  // the way into stage 2. Stage PL rounds both.
  // --------------------------------------------------------------------------
  for (genvar k = 2; k <= PL; k++) begin : g_stage
    if (k <= QW + 1) begin : g_div
      q248alu_pkg::word_t step_rem;
      logic [QW-1:0]      step_nq;

      q248alu_div_step u_step (
        .rem_i (pipe_q[k-1].rem),
        .nq_i  (pipe_q[k-1].nq),
        .dvs_i (pipe_q[k-1].dmag),
        .rem_o (step_rem),
        .nq_o  (step_nq)
      );

      always_comb begin
        pipe_d[k]     = pipe_q[k-1];
        pipe_d[k].rem = step_rem;
        pipe_d[k].nq  = step_nq;
        if (k == 2) begin
          pipe_d[k].acc = q248alu_pkg::ProdBits'(pipe_q[k-1].amag)
                          * q248alu_pkg::ProdBits'(pipe_q[k-1].dmag);
        end
      end
    end else begin : g_round
      logic half_up;

      // round half away from zero on the magnitude: 2*rem >= divisor
      assign half_up = ({pipe_q[k-1].rem, 1'b0} >= {1'b0, pipe_q[k-1].dmag});

      always_comb begin
        pipe_d[k]     = pipe_q[k-1];
        pipe_d[k].qr  = (QW + 1)'(pipe_q[k-1].nq) + (QW + 1)'(half_up);
        pipe_d[k].acc = (pipe_q[k-1].acc + MulRnd) >> F;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Final select and saturation into the output register
  // --------------------------------------------------------------------------
  always_comb begin
    case (pipe_q[PL].op)
      q248alu_pkg::OP_MUL:
        out_d = q248alu_pkg::sat_pack(pipe_q[PL].neg,
                                      q248alu_pkg::MagBits'(pipe_q[PL].acc));
      q248alu_pkg::OP_DIV:
        out_d = pipe_q[PL].dz ? pipe_q[PL].fix
                              : q248alu_pkg::sat_pack(pipe_q[PL].neg,
                                                      q248alu_pkg::MagBits'(pipe_q[PL].qr));
      default:
        out_d = pipe_q[PL].fix;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      vld_q      <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        in_vld_q <= s_axis_tvalid;
        vld_q    <= {vld_q[PL-1:1], in_vld_q};
      end
      if (!out_vld_q || m_axis_tready) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q  <= arrive;
        end
      end else if (arrive) begin
        // output is held: park the arriving result, pipe stops next cycle
        skid_vld_q <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_op_q <= q248alu_pkg::alu_op_e'(s_axis_tdata[q248alu_pkg::OpBits-1:0]);
      in_a_q  <= s_axis_tdata[q248alu_pkg::OpBits +: W];
      in_b_q  <= s_axis_tdata[q248alu_pkg::OpBits + W +: W];
      for (int unsigned i = 1; i <= PL; i++) begin
        pipe_q[i] <= pipe_d[i];
      end
    end
    if (!out_vld_q || m_axis_tready) begin
      out_q <= skid_vld_q ? skid_q : out_d;
    end else if (arrive) begin
      skid_q <= out_d;
    end
  end

endmodule

// ===== sim/q248alu_result_check.sv =====
`timescale 1ns / 100ps
// ============================================================================
// q248alu_result_check - result checker for the Q24.8 fixed-point ALU
// Watches both stream channels, predicts every accepted transaction and
// compares each returned result against the oldest outstanding prediction.
// ============================================================================
module q248alu_result_check
  import q248alu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [InDataBits-1:0]   in_data_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [OutDataBits-1:0]  out_data_i,
  output int unsigned             mismatch_count_o,
  output int unsigned             pending_o,
  output int unsigned             checked_o,
  output int unsigned             saturated_o,
  output int unsigned             div_zero_o
);

  localparam int unsigned ReportMax = 10;
  localparam longint      WordHi    = (longint'(1) <<< (WordBits - 1)) - 1;
  localparam longint      WordLo    = -(longint'(1) <<< (WordBits - 1));
  localparam longint unsigned MagLimNeg = longint'(1) << (WordBits - 1);
  localparam longint unsigned RoundHalf = longint'(1) << (FracBits - 1);

  typedef struct {
    alu_op_e op;
    word_t   a;
    word_t   b;
    result_t want;
  } alu_expect_t;

  alu_expect_t pending_results_q[$];

  // saturate a signed wide value into the word
  function automatic result_t clamp_wide(longint v);
    result_t r;
    r.res = word_t'(v);
    r.cmp = 1'b0;
    r.st  = ST_OK;
    if (v > WordHi) begin
      r.res = MaxWord;
      r.st  = ST_OVF;
    end else if (v < WordLo) begin
      r.res = MinWord;
      r.st  = ST_OVF;
    end
    return r;
  endfunction

  // saturate sign plus magnitude into the word
  function automatic result_t clamp_mag(logic neg, longint unsigned mag);
    result_t r;
    r.cmp = 1'b0;
    r.st  = ST_OK;
    if (neg) begin
      if (mag > MagLimNeg) begin
        r.res = MinWord;
        r.st  = ST_OVF;
      end else begin
        r.res = word_t'(longint'(0) - longint'(mag));
      end
    end else begin
      if (mag > longint'(WordHi)) begin
        r.res = MaxWord;
        r.st  = ST_OVF;
      end else begin
        r.res = word_t'(mag);
      end
    end
    return r;
  endfunction

  function automatic result_t predict_alu_result(alu_op_e op, word_t a, word_t b);
    longint          sa;
    longint          sb;
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned quo;
    longint unsigned rem;
    logic            neg;
    result_t         r;
    sa    = longint'($signed(a));
    sb    = longint'($signed(b));
    ma    = (sa < 0) ? longint'(0) - sa : sa;
    mb    = (sb < 0) ? longint'(0) - sb : sb;
    neg   = a[WordBits-1] ^ b[WordBits-1];
    r.res = '0;
    r.cmp = 1'b0;
    r.st  = ST_OK;
    case (op)
      OP_ADD: r = clamp_wide(sa + sb);
      OP_SUB: r = clamp_wide(sa - sb);
      OP_MUL: r = clamp_mag(neg, (ma * mb + RoundHalf) >> FracBits);
      OP_DIV: begin
        if (mb == 0) begin
          r.st = ST_DIV0;
          if (sa < 0)      r.res = MinWord;
          else if (sa > 0) r.res = MaxWord;
        end else begin
          quo = (ma << FracBits) / mb;
          rem = (ma << FracBits) % mb;
          // ties go away from zero
          if (rem >= mb - rem) quo++;
          r = clamp_mag(neg, quo);
        end
      end
      OP_INC:      r = clamp_wide(sa + 1);
      OP_DEC:      r = clamp_wide(sa - 1);
      OP_MIN:      r.res = (sa < sb) ? a : b;
      OP_MAX:      r.res = (sb < sa) ? a : b;
      OP_GT:       r.cmp = (sa > sb);
      OP_LT:       r.cmp = (sa < sb);
      OP_GE:       r.cmp = (sa >= sb);
      OP_LE:       r.cmp = (sa <= sb);
      OP_EQ:       r.cmp = (sa == sb);
      OP_NE:       r.cmp = (sa != sb);
      OP_FROM_INT: r = clamp_mag(a[WordBits-1], ma << FracBits);
      OP_TO_INT:   r.res = word_t'(sa >>> FracBits);
      default:     r.res = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alu_expect_t exp_item;
    alu_expect_t got_in;
    word_t       got_res;
    logic        got_cmp;
    status_e     got_st;
    if (!rst_ni) begin
      pending_results_q.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
      checked_o        <= 0;
      saturated_o      <= 0;
      div_zero_o       <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        got_in.op   = alu_op_e'(in_data_i[OpBits-1:0]);
        got_in.a    = in_data_i[OpBits +: WordBits];
        got_in.b    = in_data_i[OpBits + WordBits +: WordBits];
        got_in.want = predict_alu_result(got_in.op, got_in.a, got_in.b);
        pending_results_q.push_back(got_in);
      end
      if (out_valid_i && out_ready_i) begin
        got_res = out_data_i[WordBits-1:0];
        got_cmp = out_data_i[WordBits];
        got_st  = status_e'(out_data_i[WordBits+1 +: StBits]);
        if (pending_results_q.size() == 0) begin
          if (mismatch_count_o < ReportMax)
            $display("ERROR: result with nothing outstanding: res=%h cmp=%0d st=%0d",
                     got_res, got_cmp, got_st);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          exp_item = pending_results_q.pop_front();
          checked_o <= checked_o + 1;
          if (exp_item.want.st == ST_OVF)  saturated_o <= saturated_o + 1;
          if (exp_item.want.st == ST_DIV0) div_zero_o  <= div_zero_o + 1;
          if (got_res !== exp_item.want.res || got_cmp !== exp_item.want.cmp ||
              got_st !== exp_item.want.st) begin
            if (mismatch_count_o < ReportMax)
              $display("ERROR: %s a=%h b=%h: expected res=%h cmp=%0d st=%0d, got res=%h cmp=%0d st=%0d",
                       exp_item.op.name(), exp_item.a, exp_item.b,
                       exp_item.want.res, exp_item.want.cmp, exp_item.want.st,
                       got_res, got_cmp, got_st);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      pending_o <= pending_results_q.size();
    end
  end

endmodule

// ===== sim/q24_8_fixed_point_alu_top_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// q24_8_fixed_point_alu_top_test - testbench for the Q24.8 fixed-point ALU
// Directed corner transactions, then random ones with both stream sides
// stalling at random; a separate checker predicts and compares every result.
// ============================================================================
module q24_8_fixed_point_alu_top_test;
  import q248alu_pkg::*;

  localparam int unsigned RandItems  = 1480;
  localparam int unsigned IdlePct    = 18;
  localparam int unsigned CycleLimit = 200000;
  // spans the pipeline from accept to output valid, plus some margin
  localparam int unsigned DrainWait  = QuotBits + 3 + 10;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;

  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned results_checked;
  int unsigned saturated_seen;
  int unsigned div_zero_seen;
  int unsigned sent_count  = 0;
  int unsigned cycle_count = 0;
  // cleared during the quiet stretch: no stalls on either side
  logic        stall_en    = 1'b1;

  always #5 clk_i = ~clk_i;

  q24_8_fixed_point_alu_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  q248alu_result_check u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (results_pending),
    .checked_o        (results_checked),
    .saturated_o      (saturated_seen),
    .div_zero_o       (div_zero_seen)
  );

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, results_pending);
      $display("q24_8_fixed_point_alu_top verification failed");
      $finish;
    end
  end

  // result side: random backpressure while stalls are enabled
  always @(posedge clk_i) begin
    if (!rst_ni)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= !(stall_en && ($urandom_range(99) < IdlePct));
  end

  // one transaction on the input stream; tvalid stays high into the next
  // call unless that call starts with an idle cycle
  task automatic send_item(input alu_op_e op, input word_t a, input word_t b);
    while (stall_en && ($urandom_range(99) < IdlePct)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataBits'({b, a, op});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_count++;
  endtask

  // hold the input side until every outstanding result has come back;
  // the first edge lets the checker's count catch up with the last accept
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  // operand mix: full random, small, extremes, powers of two, zero
  function automatic word_t rand_operand();
    word_t v;
    case ($urandom_range(7))
      0, 1, 2: v = $urandom;
      3:       v = word_t'(int'($urandom_range(2047)) - 1024);
      4: begin
        case ($urandom_range(5))
          0:       v = MaxWord;
          1:       v = MinWord;
          2:       v = MaxWord - 1;
          3:       v = MinWord + 1;
          4:       v = '1;
          default: v = word_t'(1);
        endcase
      end
      5:       v = word_t'(1) << $urandom_range(WordBits - 1);
      6:       v = word_t'(int'($urandom_range(131071)) - 65536);
      default: v = '0;
    endcase
    // occasionally flip the sign of what was picked
    if ($urandom_range(3) == 0) v = -v;
    return v;
  endfunction

  initial begin
    word_t   ra;
    word_t   rb;
    alu_op_e rop;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed corners ----
    send_item(OP_ADD, MaxWord, 32'sd1);                 // positive overflow
    send_item(OP_ADD, MinWord, -32'sd1);                // negative overflow
    send_item(OP_SUB, MinWord, 32'sd1);
    send_item(OP_SUB, MaxWord, -32'sd1);
    send_item(OP_MUL, MaxWord, MaxWord);                // saturates high
    send_item(OP_MUL, 32'sd128, 32'sd1);                // rounding tie, away from zero
    send_item(OP_MUL, 32'sh180, -32'sd128);             // 1.5 * -0.5
    send_item(OP_DIV, 32'sd5, '0);                      // divide by zero, positive
    send_item(OP_DIV, -32'sd5, '0);                     // divide by zero, negative
    send_item(OP_DIV, '0, '0);                          // divide by zero, zero dividend
    send_item(OP_DIV, MinWord, -32'sd256);              // min / -1.0 overflows
    send_item(OP_INC, MaxWord, '0);
    send_item(OP_DEC, MinWord, '0);
    send_item(OP_MIN, MinWord, MaxWord);
    send_item(OP_MAX, MinWord, MaxWord);
    send_item(OP_GT, MaxWord, MinWord);
    send_item(OP_LT, MaxWord, MinWord);
    send_item(OP_GE, 32'sd7, 32'sd7);
    send_item(OP_LE, -32'sd1, '0);
    send_item(OP_EQ, MinWord, MinWord);
    send_item(OP_NE, MinWord, MinWord);
    send_item(OP_FROM_INT, 32'sh0080_0000, '0);         // just past the top
    send_item(OP_FROM_INT, -32'sh0080_0000, '0);        // exactly the bottom
    send_item(OP_TO_INT, -32'sd1, '0);                  // floors to -1
    send_item(OP_TO_INT, MinWord, MaxWord);

    // sender holds off until the pipeline has fully drained
    wait_results_drained();

    // ---- random traffic ----
    for (int i = 0; i < RandItems; i++) begin
      stall_en = !(i >= 400 && i < 700);
      if (i == 900) wait_results_drained();
      rop = alu_op_e'($urandom_range(15));
      ra  = rand_operand();
      rb  = ($urandom_range(7) == 0) ? ra : rand_operand();
      send_item(rop, ra, rb);
    end

    wait_results_drained();
    repeat (DrainWait) @(posedge clk_i);

    $display("%0d transactions sent (all 16 operations, operand extremes, rounding ties)",
             sent_count);
    $display("%0d results checked, %0d saturated, %0d divide-by-zero, %0d mismatches",
             results_checked, saturated_seen, div_zero_seen, mismatch_count);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("q24_8_fixed_point_alu_top verification clean");
    end else begin
      $display("q24_8_fixed_point_alu_top verification failed");
    end
    $finish;
  end

endmodule
